/* design/itrs_pkg.sv */
// ----------------------------------------------------------------------------
// itrs_pkg: shared types and constants for the radix symbol renderer
// Holds the sequencer state type, register indexes, symbol codes and the
// default sizes used by the top level.
// ----------------------------------------------------------------------------
package itrs_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEF_MAX_SYMBOLS = 16;
    localparam int DEF_VALUE_BITS  = 32;

    // Fixed field and port widths.
    localparam int VALUE_W    = 32;
    localparam int SYM_W      = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 5;

    // Symbols per 64-bit alphabet register and dividend bits per divide step.
    localparam int BANK_SYMS = 8;
    localparam int CHUNK_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH  = 2'd2;

    // Symbol codes with a fixed meaning.
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_EMIT
    } t_state;

endpackage

/* design/integer_to_radix_symbols.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_symbols: signed integer to symbol run in a configured radix
// Renders one signed value per item as 8-bit symbols, sign first, then the
// digits of the magnitude most significant first, using a configured alphabet.
// ----------------------------------------------------------------------------
// Sequence: IDLE accepts the item, CHECK tests one alphabet symbol per step,
//   DIVIDE forms each digit (8 dividend bits per cycle), SIGN loads a minus
//   sign for a negative value, then FETCH and EMIT load each digit symbol.
// One item at a time; the next item is taken once the last symbol is loaded
//   into the output register, and output stalls delay that.
// Reset clears all control state and the configuration registers to zero.
module integer_to_radix_symbols
    import itrs_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_W-1:0]    i_value,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SYM_W-1:0]      o_symbol,
    output logic                  o_last
);

    localparam int DIGIT_W  = $clog2(MAX_SYMBOLS);
    localparam int STEPS    = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_BITS = STEPS * CHUNK_W;
    localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W    = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W   = $clog2(VALUE_BITS);

    // Registers
    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_symbol_count;
    logic [SYM_W-1:0]      r_alpha [MAX_SYMBOLS];
    logic [COUNT_W-1:0]    r_radix, n_radix;
    logic                  r_neg, n_neg;
    logic [PAD_BITS-1:0]   r_mag, n_mag;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [DIGIT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [DIGIT_W-1:0]    r_stack [VALUE_BITS];
    logic [DIGIT_W-1:0]    r_rd_digit;
    logic                  r_out_valid;
    logic [SYM_W-1:0]      r_out_symbol;
    logic                  r_out_last;

    // Combinational signals
    logic                  in_accept;
    logic                  out_free;
    logic                  load_sign;
    logic                  load_digit;
    logic                  push;
    logic [VALUE_BITS-1:0] in_raw;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  cnt_ok;
    logic [SYM_W-1:0]      cur_sym;
    logic                  bad_sym;
    logic                  dup;
    logic                  check_done;
    logic                  check_fail;
    logic [DIGIT_W-1:0]    rem_v;
    logic [DIGIT_W:0]      trial;
    logic [CHUNK_W-1:0]    qbits;
    logic [PAD_BITS-1:0]   div_quot;
    logic                  step_last;

    // Handshake control.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
        in_accept   = i_in_valid && !o_in_stall;
        out_free    = !r_out_valid || !i_out_stall;
        load_sign   = (r_state == ST_SIGN) && out_free;
        load_digit  = (r_state == ST_EMIT) && out_free;
        push        = (r_state == ST_DIVIDE) && step_last;
    end

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= '0;
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                r_alpha[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_SYMBOL_COUNT) begin
                r_symbol_count <= i_cfg_data[COUNT_W-1:0];
            end
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                if (k < BANK_SYMS) begin
                    if (i_cfg_index == REG_DIGITS_LOW) begin
                        r_alpha[k] <= i_cfg_data[k*SYM_W +: SYM_W];
                    end
                end else if (i_cfg_index == REG_DIGITS_HIGH) begin
                    r_alpha[k] <= i_cfg_data[(k-BANK_SYMS)*SYM_W +: SYM_W];
                end
            end
        end
    end

    // Sign and magnitude of the incoming value; the most negative value
    // maps onto its own bit pattern, which is the correct unsigned magnitude.
    always_comb begin
        in_raw = i_value[VALUE_BITS-1:0];
        in_mag = in_raw[VALUE_BITS-1] ? (~in_raw + VALUE_BITS'(1)) : in_raw;
    end

    // Alphabet check: one symbol per cycle against sign codes, the
    // terminator code and every later symbol in the alphabet.
    always_comb begin
        cnt_ok  = (r_radix >= COUNT_W'(2)) && (r_radix <= COUNT_W'(MAX_SYMBOLS));
        cur_sym = r_alpha[r_idx];
        bad_sym = (cur_sym == SYM_NUL) || (cur_sym == SYM_MINUS) ||
                  (cur_sym == SYM_PLUS);
        dup = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if ((COUNT_W'(j) > COUNT_W'(r_idx)) && (COUNT_W'(j) < r_radix) &&
                (r_alpha[j] == cur_sym)) begin
                dup = 1'b1;
            end
        end
        check_fail = !cnt_ok || bad_sym || dup;
        check_done = (COUNT_W'(r_idx) + COUNT_W'(1) == r_radix);
    end

    // Shared divide unit: restoring long division by the radix, eight
    // dividend bits per cycle; quotient bits shift in at the bottom.
    always_comb begin
        rem_v = r_rem;
        qbits = '0;
        trial = '0;
        for (int b = CHUNK_W - 1; b >= 0; b--) begin
            trial = {rem_v, r_mag[PAD_BITS-CHUNK_W+b]};
            if (COUNT_W'(trial) >= r_radix) begin
                rem_v    = DIGIT_W'(COUNT_W'(trial) - r_radix);
                qbits[b] = 1'b1;
            end else begin
                rem_v    = trial[DIGIT_W-1:0];
                qbits[b] = 1'b0;
            end
        end
        div_quot  = (r_mag << CHUNK_W) | PAD_BITS'(qbits);
        step_last = (r_step == STEP_W'(STEPS - 1));
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (check_fail) begin
                    n_state = ST_IDLE;
                end else if (check_done) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (step_last && (div_quot == '0)) begin
                    n_state = r_neg ? ST_SIGN : ST_FETCH;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_count == '0) ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath next values driven by the sequencer state.
    always_comb begin
        n_radix = r_radix;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_step  = r_step;
        n_idx   = r_idx;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_radix = r_symbol_count;
                    n_neg   = in_raw[VALUE_BITS-1];
                    n_mag   = PAD_BITS'(in_mag);
                    n_rem   = '0;
                    n_step  = '0;
                    n_idx   = '0;
                    n_count = '0;
                end
            end
            ST_CHECK: begin
                n_idx = r_idx + DIGIT_W'(1);
            end
            ST_DIVIDE: begin
                n_mag = div_quot;
                if (step_last) begin
                    n_step  = '0;
                    n_rem   = '0;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_step = r_step + STEP_W'(1);
                    n_rem  = rem_v;
                end
            end
            ST_FETCH: begin
                n_count = r_count - CNT_W'(1);
            end
            ST_SIGN, ST_EMIT: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_idx   <= n_idx;
        end
    end

    // Payload registers of the working value.
    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_rem   <= n_rem;
    end

    // Digit stack: digits are pushed least significant first and popped
    // in reverse; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_count[ADDR_W-1:0]] <= rem_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH) begin
            r_rd_digit <= r_stack[n_count[ADDR_W-1:0]];
        end
    end

    // Output register: refilled when empty or when its symbol transfers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= load_sign || load_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_sign) begin
            r_out_symbol <= SYM_MINUS;
            r_out_last   <= 1'b0;
        end else if (load_digit) begin
            r_out_symbol <= r_alpha[r_rd_digit];
            r_out_last   <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_symbol;
    assign o_last      = r_out_last;

    // The partial remainder always stays below the radix while dividing.
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (COUNT_W'(r_rem) < r_radix))
        else $error("divide remainder reached the radix");

    // The digit stack never holds more digits than the value has bits.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VALUE_BITS))
        else $error("digit stack overflow");

    // An accepted item always starts with the alphabet check.
    a_accept_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_CHECK))
        else $error("accepted item skipped the alphabet check");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_to_radix_symbols
// Programs the alphabet, sends signed values and compares every symbol
// transfer against a predicted run: optional minus sign, then the digits of
// the magnitude in the configured radix. Unusable alphabets must give nothing.
// ----------------------------------------------------------------------------
module tb
    import itrs_pkg::*;
();

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 200;
    localparam int CALM_ITEMS    = 24;

    // Index past the defined registers; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One expected symbol of a rendered run.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             is_last;
    } t_symbol_item;

    // Tracks the alphabet registers and the symbols still owed by the block.
    class radix_board;
        logic [4:0]            sym_count;
        logic [CFG_DATA_W-1:0] digits_lo;
        logic [CFG_DATA_W-1:0] digits_hi;
        t_symbol_item          pending[$];
        int unsigned           error_count;

        function new();
            sym_count   = '0;
            digits_lo   = '0;
            digits_hi   = '0;
            error_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SYMBOL_COUNT: sym_count = data[4:0];
                REG_DIGITS_LOW:   digits_lo = data;
                REG_DIGITS_HIGH:  digits_hi = data;
                default: ;
            endcase
        endfunction

        function logic [SYM_W-1:0] symbol_of(int unsigned digit);
            logic [2*CFG_DATA_W-1:0] alpha;
            alpha = {digits_hi, digits_lo};
            return alpha[8*(digit % 16) +: 8];
        endfunction

        // Radix of the current alphabet, or zero when it cannot be used.
        function int unsigned usable_radix();
            bit [255:0]       seen;
            logic [SYM_W-1:0] s;
            int unsigned      n;
            seen = '0;
            n = sym_count;
            if (n < 2 || n > DEF_MAX_SYMBOLS) return 0;
            for (int i = 0; i < n; i++) begin
                s = symbol_of(i);
                if (s == SYM_NUL || s == SYM_MINUS || s == SYM_PLUS || seen[s]) return 0;
                seen[s] = 1'b1;
            end
            return n;
        endfunction

        // Renders an accepted value into the symbols the block must emit.
        function void note_value(logic [VALUE_W-1:0] v);
            bit [3:0]        digit_q[$];
            longint unsigned mag;
            int unsigned     radix;
            t_symbol_item    item;
            radix = usable_radix();
            if (radix == 0) return;
            mag = v[VALUE_W-1] ? (64'h1_0000_0000 - {32'h0, v}) : {32'h0, v};
            if (mag == 0) digit_q.push_front(4'd0);
            while (mag != 0) begin
                digit_q.push_front(4'(mag % radix));
                mag = mag / radix;
            end
            if (v[VALUE_W-1]) begin
                item.sym     = SYM_MINUS;
                item.is_last = 1'b0;
                pending.push_back(item);
            end
            foreach (digit_q[i]) begin
                item.sym     = symbol_of(digit_q[i]);
                item.is_last = (i == digit_q.size() - 1);
                pending.push_back(item);
            end
        endfunction

        task report_mismatch(string msg);
            error_count++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        // Compares one symbol transfer with the oldest expectation.
        task check_symbol(logic [SYM_W-1:0] sym, logic is_last);
            t_symbol_item want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol 0x%02h last=%0b", sym, is_last));
                return;
            end
            want = pending.pop_front();
            if (sym !== want.sym)
                report_mismatch($sformatf("symbol 0x%02h, want 0x%02h", sym, want.sym));
            if (is_last !== want.is_last)
                report_mismatch($sformatf("last %0b, want %0b (symbol 0x%02h)",
                                          is_last, want.is_last, want.sym));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [VALUE_W-1:0]    i_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [SYM_W-1:0]      o_symbol;
    logic                  o_last;

    radix_board  board;
    bit          calm;
    logic        hold_off_req;
    int unsigned cycles;
    int unsigned items_counted;

    integer_to_radix_symbols i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog on the total run length.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check every symbol transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_symbol(o_symbol, o_last);
    end

    // Result side back-pressure: random bursts plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req <= 1'b0;
                i_out_stall  <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Write one register; called and returns just after a falling edge.
    task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Program all three alphabet registers; upper count bits carry noise.
    task set_alphabet(logic [4:0] count, logic [CFG_DATA_W-1:0] lo,
                      logic [CFG_DATA_W-1:0] hi);
        logic [CFG_DATA_W-1:0] count_word;
        count_word = {$urandom, $urandom};
        count_word[4:0] = count;
        cfg_write(REG_SYMBOL_COUNT, count_word);
        cfg_write(REG_DIGITS_LOW, lo);
        cfg_write(REG_DIGITS_HIGH, hi);
    endtask

    // Offer one value and hold it until the block takes it.
    task send_value(logic [VALUE_W-1:0] v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        if (board.usable_radix() != 0) items_counted++;
        board.note_value(v);
        @(negedge i_clk);
    endtask

    // Wait until every owed symbol arrived, then let the block go quiet.
    task settle_block();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value(int unsigned radix);
        longint unsigned p;
        int              k;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6: begin
                v = $urandom_range(0, 300);
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            8: begin
                // Around a power of the radix, where the digit count changes.
                p = 1;
                k = $urandom_range(1, 31);
                while (k > 0 && p * radix <= 64'h8000_0000) begin
                    p = p * radix;
                    k--;
                end
                v = p[31:0] - $urandom_range(0, 1);
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            default: begin
                v = 32'h1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) != 0) v = -v;
            end
        endcase
        return v;
    endfunction

    // One random alphabet, mostly usable, then a batch of values under it.
    task random_phase(int n_items, bit pressure);
        logic [2*CFG_DATA_W-1:0] alpha;
        bit [255:0]  used;
        int          count;
        int          i;
        int          j;
        int unsigned b;
        used  = '0;
        count = pressure ? $urandom_range(2, 3) : $urandom_range(2, 16);
        for (i = 0; i < 16; i++) begin
            if (i < count) begin
                do b = $urandom_range(1, 255);
                while (used[b] || b == SYM_PLUS || b == SYM_MINUS);
                used[b] = 1'b1;
            end else begin
                b = $urandom_range(0, 255);
            end
            alpha[8*i +: 8] = b[7:0];
        end
        if (!pressure && $urandom_range(0, 4) == 0) begin
            // Break the alphabet in one of the ways that must silence the block.
            n_items = 3;
            case ($urandom_range(0, 4))
                0: count = $urandom_range(0, 1);
                1: count = $urandom_range(17, 31);
                2: begin
                    j = $urandom_range(1, count - 1);
                    i = $urandom_range(0, j - 1);
                    alpha[8*j +: 8] = alpha[8*i +: 8];
                end
                3: alpha[8*$urandom_range(0, count - 1) +: 8] =
                       ($urandom_range(0, 1) != 0) ? SYM_PLUS : SYM_MINUS;
                default: alpha[8*$urandom_range(0, count - 1) +: 8] = SYM_NUL;
            endcase
        end
        set_alphabet(count[4:0], alpha[63:0], alpha[127:64]);
        if (pressure) hold_off_req <= 1'b1;
        repeat (n_items) send_value(random_value(board.usable_radix()));
        settle_block();
    endtask

    initial begin
        board         = new();
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        items_counted = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_value       = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Registers are zero after reset: the alphabet is empty, no output.
        send_value(32'd5);
        settle_block();

        // Decimal, with signs and repeats parked above the used symbols.
        set_alphabet(5'd10, "76543210",
                     {SYM_PLUS, SYM_MINUS, SYM_NUL, 8'h30, 8'h30, 8'h30, "98"});
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1000000000);
        send_value(-32'sd10);
        settle_block();

        // Binary gives the longest run for the most negative value.
        set_alphabet(5'd2, {{6{8'h31}}, "10"}, {8{8'h2D}});
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
        settle_block();

        // Full sixteen-symbol alphabet whose last symbol is 0xFF.
        set_alphabet(5'd16, "76543210", {8'hFF, "EDCBA98"});
        send_value(32'h8000_0000);
        send_value(32'hDEAD_BEEF);
        send_value(32'h7FFF_FFFF);
        settle_block();

        // Unusable alphabets: too short, too long, repeated, sign, zero byte.
        set_alphabet(5'd1, "76543210", "FEDCBA98");
        send_value(32'd7);
        settle_block();
        set_alphabet(5'd17, "76543210", "FEDCBA98");
        send_value(32'd7);
        settle_block();
        cfg_write(REG_SYMBOL_COUNT, 64'd31);
        send_value(32'hFFFF_FFF9);
        settle_block();
        set_alphabet(5'd4, 64'h0000_0000_FF41_FF30, 64'h0);
        send_value(32'd3);
        settle_block();
        set_alphabet(5'd3, 64'h0000_0000_002B_3130, 64'h0);
        send_value(32'd2);
        settle_block();
        set_alphabet(5'd3, 64'h0000_0000_002D_3130, 64'h0);
        send_value(32'd2);
        settle_block();
        set_alphabet(5'd3, 64'h4141_4141_4100_3130, 64'h0);
        send_value(32'd2);
        settle_block();

        // A write to the spare index must leave the ternary alphabet intact.
        set_alphabet(5'd3, "xxxxx210", 64'h0);
        cfg_write(REG_UNUSED, {$urandom, $urandom});
        send_value(32'd8);
        send_value(32'hFFFF_FFF8);
        settle_block();

        // Random phases, one of them with a long hold-off on the results.
        items_counted = 0;
        random_phase(12, 1'b0);
        random_phase(20, 1'b1);
        while (items_counted < RANDOM_ITEMS)
            random_phase($urandom_range(8, 24), 1'b0);

        // Closing stretch at full rate on both sides.
        calm = 1'b1;
        random_phase(CALM_ITEMS, 1'b0);

        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
